[rtl/priority_inheritance_mutex_macros.svh]
// Assertion macros for the priority inheritance mutex
`ifndef PRIORITY_INHERITANCE_MUTEX_MACROS_SVH
`define PRIORITY_INHERITANCE_MUTEX_MACROS_SVH

`ifndef SYNTHESIS
`define PIM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pim: property violated");
`define PIM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pim: forbidden condition seen");
`else
`define PIM_ASSERT(lbl, clk, rstn, prop)
`define PIM_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/pim_pkg.sv]
// Package: constants, codes and shared types of the priority inheritance mutex
`timescale 1ns / 1ps
package pim_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_NESTING = 255;

  localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NEST_W  = $clog2(MAX_NESTING + 1);
  localparam int TID_W   = 8;
  localparam int PRIO_W  = 8;
  localparam int ENTRY_W = TID_W + PRIO_W;

  localparam logic [PRIO_W-1:0] PRIO_RESET = 8'hff;

  typedef enum logic [1:0] {
    KIND_TAKE    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DESTROY = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_DESTROYED = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_FULL      = 3'd4,
    ST_NEST_OVF  = 3'd5
  } status_e;

  typedef struct packed {
    logic               rd;
    logic               push;
    logic               pop;
    logic               clear;
    logic [ENTRY_W-1:0] wdata;
  } qcmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0]  count;
    logic               full;
    logic               empty;
    logic [ENTRY_W-1:0] rdata;
  } qstat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              prio_update_valid;
    logic [TID_W-1:0]  prio_thread;
    logic [PRIO_W-1:0] prio_value;
    logic              wake_valid;
    logic [TID_W-1:0]  wake_thread;
  } rsp_t;

endpackage

[rtl/pim_req_if.sv]
// Request channel: kind, thread and priority of one item
`timescale 1ns / 1ps
interface pim_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] thread_id;
  logic [7:0] thread_prio;

  modport source (output valid, output kind, output thread_id, output thread_prio,
                  input ready);
  modport sink   (input valid, input kind, input thread_id, input thread_prio,
                  output ready);
endinterface

[rtl/pim_rsp_if.sv]
// Response channel: status, priority change and hand-off of one item
`timescale 1ns / 1ps
interface pim_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       prio_update_valid;
  logic [7:0] prio_thread;
  logic [7:0] prio_value;
  logic       wake_valid;
  logic [7:0] wake_thread;

  modport source (output valid, output status, output prio_update_valid,
                  output prio_thread, output prio_value, output wake_valid,
                  output wake_thread, input ready);
  modport sink   (input valid, input status, input prio_update_valid,
                  input prio_thread, input prio_value, input wake_valid,
                  input wake_thread, output ready);
endinterface

[rtl/pim_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pim_queue.sv]
// Waiter FIFO: head/tail/count pointers around the waiter RAM
`timescale 1ns / 1ps
module pim_queue
  import pim_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qcmd_t  cmd_i,
  output qstat_t stat_o
);

  logic [QIDX_W-1:0] head_q, head_d;
  logic [QIDX_W-1:0] tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [ENTRY_W-1:0] rdata;

  function automatic logic [QIDX_W-1:0] next_slot(input logic [QIDX_W-1:0] p);
    return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + QIDX_W'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q + QCNT_W'(1);
    end else if (cmd_i.pop) begin
      head_d  = next_slot(head_q);
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  pim_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && !cmd_i.clear),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q >= QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.rdata = rdata;

endmodule

[rtl/pim_ctrl.sv]
// Lock state, request sequencer and response register
`timescale 1ns / 1ps
module pim_ctrl
  import pim_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  pim_req_if.sink   req,
  pim_rsp_if.source rsp,
  output qcmd_t     qcmd_o,
  input  qstat_t    qstat_i
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic              rec_en_q;
  logic              destroyed_q, destroyed_d;
  logic              owned_q, owned_d;
  logic [TID_W-1:0]  owner_id_q, owner_id_d;
  logic [PRIO_W-1:0] cur_prio_q, cur_prio_d;
  logic [PRIO_W-1:0] saved_prio_q, saved_prio_d;
  logic [NEST_W-1:0] nesting_q, nesting_d;
  logic [1:0]        kind_q;
  logic [TID_W-1:0]  tid_q;
  logic [PRIO_W-1:0] prio_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, res;
  logic              accept, fire;

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  // the result register may still hold the previous item; wait until it drains
  assign fire      = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

  always_comb begin
    destroyed_d  = destroyed_q;
    owned_d      = owned_q;
    owner_id_d   = owner_id_q;
    cur_prio_d   = cur_prio_q;
    saved_prio_d = saved_prio_q;
    nesting_d    = nesting_q;
    res          = '0;
    res.status   = ST_OK;
    qcmd_o       = '0;
    qcmd_o.rd    = accept;
    qcmd_o.wdata = {tid_q, prio_q};

    case (kind_q)
      KIND_DESTROY: begin
        destroyed_d  = 1'b1;
        owned_d      = 1'b0;
        owner_id_d   = '0;
        cur_prio_d   = '0;
        nesting_d    = '0;
        qcmd_o.clear = fire;
      end
      KIND_TAKE: begin
        if (destroyed_q) begin
          res.status = ST_DESTROYED;
        end else if (!owned_q) begin
          owned_d      = 1'b1;
          owner_id_d   = tid_q;
          cur_prio_d   = prio_q;
          saved_prio_d = prio_q;
          nesting_d    = '0;
        end else if (rec_en_q && owner_id_q == tid_q) begin
          if (nesting_q >= NEST_W'(MAX_NESTING)) begin
            res.status = ST_NEST_OVF;
          end else begin
            nesting_d = nesting_q + NEST_W'(1);
          end
        end else if (qstat_i.full) begin
          res.status = ST_FULL;
        end else begin
          qcmd_o.push = fire;
          res.status  = ST_QUEUED;
          if (prio_q > cur_prio_q) begin
            cur_prio_d            = prio_q;
            res.prio_update_valid = 1'b1;
            res.prio_thread       = owner_id_q;
            res.prio_value        = prio_q;
          end
        end
      end
      KIND_RELEASE: begin
        if (destroyed_q) begin
          res.status = ST_DESTROYED;
        end else if (!owned_q || owner_id_q != tid_q) begin
          res.status = ST_NOT_OWNER;
        end else if (rec_en_q && nesting_q != '0) begin
          nesting_d = nesting_q - NEST_W'(1);
        end else begin
          if (saved_prio_q != prio_q) begin
            res.prio_update_valid = 1'b1;
            res.prio_thread       = tid_q;
            res.prio_value        = saved_prio_q;
          end
          nesting_d = '0;
          if (!qstat_i.empty) begin
            // hand the lock to the head waiter read during the accept cycle
            qcmd_o.pop      = fire;
            owner_id_d      = qstat_i.rdata[ENTRY_W-1:PRIO_W];
            cur_prio_d      = qstat_i.rdata[PRIO_W-1:0];
            saved_prio_d    = qstat_i.rdata[PRIO_W-1:0];
            res.wake_valid  = 1'b1;
            res.wake_thread = qstat_i.rdata[ENTRY_W-1:PRIO_W];
          end else begin
            owned_d    = 1'b0;
            owner_id_d = '0;
            cur_prio_d = '0;
          end
        end
      end
      default: begin
        // undefined kind: answered with ok, no change
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp.ready;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rec_en_q     <= 1'b0;
      destroyed_q  <= 1'b0;
      owned_q      <= 1'b0;
      owner_id_q   <= '0;
      cur_prio_q   <= '0;
      saved_prio_q <= PRIO_RESET;
      nesting_q    <= '0;
      kind_q       <= '0;
      tid_q        <= '0;
      prio_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rec_en_q <= cfg_wdata_i;
      end
      if (accept) begin
        kind_q <= req.kind;
        tid_q  <= req.thread_id;
        prio_q <= req.thread_prio;
      end
      if (fire) begin
        destroyed_q  <= destroyed_d;
        owned_q      <= owned_d;
        owner_id_q   <= owner_id_d;
        cur_prio_q   <= cur_prio_d;
        saved_prio_q <= saved_prio_d;
        nesting_q    <= nesting_d;
        out_q        <= res;
      end
    end
  end

  assign rsp.valid             = out_valid_q;
  assign rsp.status            = out_q.status;
  assign rsp.prio_update_valid = out_q.prio_update_valid;
  assign rsp.prio_thread       = out_q.prio_thread;
  assign rsp.prio_value        = out_q.prio_value;
  assign rsp.wake_valid        = out_q.wake_valid;
  assign rsp.wake_thread       = out_q.wake_thread;

endmodule

[rtl/priority_inheritance_mutex.sv]
// Hardware mutex with a FIFO of waiters and priority inheritance.
// Each item goes through two steps: the head waiter is read from the queue RAM, whose
// read data is registered, and then the lock state is updated and the result register
// loaded. A new item is taken while the previous result still waits on the response
// channel; the update stalls only when that result has not yet been taken. The waiter
// RAM needs no clearing after reset, since only entries counted by the FIFO are used.
`timescale 1ns / 1ps
`include "priority_inheritance_mutex_macros.svh"
module priority_inheritance_mutex
  import pim_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  pim_req_if.sink   req,
  pim_rsp_if.source rsp
);

  qcmd_t  qcmd;
  qstat_t qstat;

  pim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp),
    .qcmd_o      (qcmd),
    .qstat_i     (qstat)
  );

  pim_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (qcmd),
    .stat_o (qstat)
  );

  `PIM_NEVER(a_no_push_full, clk_i, rst_ni, qcmd.push && qstat.full)
  `PIM_NEVER(a_no_pop_empty, clk_i, rst_ni, qcmd.pop && qstat.empty)
  `PIM_NEVER(a_count_bound, clk_i, rst_ni, qstat.count > QCNT_W'(QUEUE_DEPTH))
  `PIM_ASSERT(a_one_at_a_time, clk_i, rst_ni, req.valid && req.ready |=> !req.ready)

endmodule
